[hw/rtl/cfru_pkg.sv]
// Shared constants, types and microcode for the command frame responder.
// Depends on nothing; the responder unit and the CRC unit import it.
`default_nettype none

package cfru_pkg;

  // Frame bytes and fixed payload values.
  localparam logic [7:0] SOF_BYTE  = 8'hAA;
  localparam logic [7:0] EOF_BYTE  = 8'h55;
  localparam logic [7:0] NOP_BYTE  = 8'h00;
  localparam logic [7:0] ACK_BYTE  = 8'h01;
  localparam logic [7:0] DATA_MARK = 8'h02;
  localparam logic [7:0] NAK_BYTE  = 8'hFF;
  localparam logic [7:0] PAD_BYTE  = 8'h00;

  // CRC-16/XMODEM generator polynomial.
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Status register reset values and clock settings.
  localparam logic [31:0] KHZ_FAST         = 32'd200000;
  localparam logic [31:0] KHZ_BASE         = 32'd133000;
  localparam logic [31:0] ANALOG_RATE_RST  = 32'd50000;
  localparam logic [31:0] DIGITAL_RATE_RST = 32'd50000000;

  // Command codes.
  localparam logic [7:0] CMD_NOP       = 8'd0;
  localparam logic [7:0] CMD_STATUS    = 8'd1;
  localparam logic [7:0] CMD_START     = 8'd2;
  localparam logic [7:0] CMD_STOP      = 8'd3;
  localparam logic [7:0] CMD_RATE_WR   = 8'd4;
  localparam logic [7:0] CMD_SAMPLE_RD = 8'd5;
  localparam logic [7:0] CMD_MODE_WR   = 8'd6;
  localparam logic [7:0] CMD_CLK_BOOST = 8'd8;
  localparam logic [7:0] CMD_SELF_TEST = 8'd9;
  localparam logic [7:0] CMD_FAULT_INJ = 8'd10;

  // Argument selectors.
  localparam logic [7:0] TEST_VOLT   = 8'd0;
  localparam logic [7:0] TEST_TEMP   = 8'd1;
  localparam logic [7:0] TEST_CLOCK  = 8'd2;
  localparam logic [7:0] OC_FAST_SEL = 8'd1;

  // Configuration register indexes.
  localparam logic [1:0] REG_NODE  = 2'd0;
  localparam logic [1:0] REG_DRATE = 2'd1;
  localparam logic [1:0] REG_FAULT = 2'd2;

  // Payload lengths.
  typedef logic [4:0] len_t;
  localparam len_t LEN_SHORT  = 5'd1;
  localparam len_t LEN_TEST   = 5'd5;
  localparam len_t LEN_DATA   = 5'd11;
  localparam len_t LEN_STATUS = 5'd28;

  // Microprogram addresses.
  typedef logic [5:0] pc_t;
  localparam pc_t PC_SOF     = 6'd0;
  localparam pc_t PC_TRAILER = 6'd3;
  localparam pc_t PC_NOP     = 6'd6;
  localparam pc_t PC_ACK     = 6'd7;
  localparam pc_t PC_NAK     = 6'd8;
  localparam pc_t PC_TEST    = 6'd9;
  localparam pc_t PC_DATA    = 6'd14;
  localparam pc_t PC_STATUS  = 6'd25;
  localparam pc_t PC_LAST    = 6'd52;

  // Byte source of one microcode step.
  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_WORD,
    SRC_CRC_LO,
    SRC_CRC_HI
  } src_kind_t;

  // Datapath word that a SRC_WORD step takes a byte from.
  typedef enum logic [3:0] {
    WD_LEN,
    WD_NODE,
    WD_MODE,
    WD_RUN,
    WD_ARATE,
    WD_DRATE,
    WD_SAMPLES,
    WD_CLOCK,
    WD_FAULT,
    WD_TEMP,
    WD_ADC0,
    WD_ADC1,
    WD_ADC2,
    WD_ADC3,
    WD_PINS,
    WD_TEST
  } word_sel_t;

  // Next-address control.
  typedef enum logic [1:0] {
    JMP_SEQ,
    JMP_GOTO,
    JMP_DISPATCH
  } jump_t;

  // One control word of the microprogram.
  typedef struct packed {
    src_kind_t  kind;
    logic [7:0] value;
    word_sel_t  word;
    logic [1:0] idx;
    logic       crc;
    logic       last;
    jump_t      jump;
    pc_t        target;
  } ucw_t;

  // CRC unit controls.
  typedef struct packed {
    logic clear;
    logic update;
  } crc_ctl_t;

  localparam ucw_t UCW_IDLE = '{kind: SRC_CONST, value: 8'h00, word: WD_LEN, idx: 2'd0,
                                crc: 1'b0, last: 1'b0, jump: JMP_SEQ, target: PC_SOF};

  // Step that emits a constant byte.
  function automatic ucw_t cb(input logic [7:0] v, input logic crc);
    ucw_t w;
    w = UCW_IDLE;
    w.kind = SRC_CONST;
    w.value = v;
    w.crc = crc;
    return w;
  endfunction

  // Step that emits one byte of a datapath word.
  function automatic ucw_t wb(input word_sel_t s, input logic [1:0] idx, input logic crc);
    ucw_t w;
    w = UCW_IDLE;
    w.kind = SRC_WORD;
    w.word = s;
    w.idx = idx;
    w.crc = crc;
    return w;
  endfunction

  // Same step, followed by a jump to the frame trailer.
  function automatic ucw_t go_trailer(input ucw_t w_in);
    ucw_t w;
    w = w_in;
    w.jump = JMP_GOTO;
    w.target = PC_TRAILER;
    return w;
  endfunction

  // Microprogram ROM: one response byte per step.
  function automatic ucw_t ucode(input pc_t pc);
    ucw_t w;
    w = UCW_IDLE;
    unique case (pc)
      // Header, then branch to the command routine.
      PC_SOF:          w = cb(SOF_BYTE, 1'b0);
      PC_SOF + 6'd1:   w = wb(WD_LEN, 2'd0, 1'b0);
      PC_SOF + 6'd2: begin
        w = cb(PAD_BYTE, 1'b0);
        w.jump = JMP_DISPATCH;
      end
      // Trailer: CRC low, CRC high, end of frame.
      PC_TRAILER: begin
        w = UCW_IDLE;
        w.kind = SRC_CRC_LO;
      end
      PC_TRAILER + 6'd1: begin
        w = UCW_IDLE;
        w.kind = SRC_CRC_HI;
      end
      PC_TRAILER + 6'd2: begin
        w = cb(EOF_BYTE, 1'b0);
        w.last = 1'b1;
      end
      // Single-byte replies.
      PC_NOP:          w = go_trailer(cb(NOP_BYTE, 1'b1));
      PC_ACK:          w = go_trailer(cb(ACK_BYTE, 1'b1));
      PC_NAK:          w = go_trailer(cb(NAK_BYTE, 1'b1));
      // Hardware test reply.
      PC_TEST:         w = cb(ACK_BYTE, 1'b1);
      PC_TEST + 6'd1:  w = wb(WD_TEST, 2'd0, 1'b1);
      PC_TEST + 6'd2:  w = wb(WD_TEST, 2'd1, 1'b1);
      PC_TEST + 6'd3:  w = wb(WD_TEST, 2'd2, 1'b1);
      PC_TEST + 6'd4:  w = go_trailer(wb(WD_TEST, 2'd3, 1'b1));
      // Data reply: acknowledge, four samples, marker, pin levels.
      PC_DATA:         w = cb(ACK_BYTE, 1'b1);
      PC_DATA + 6'd1:  w = wb(WD_ADC0, 2'd0, 1'b1);
      PC_DATA + 6'd2:  w = wb(WD_ADC0, 2'd1, 1'b1);
      PC_DATA + 6'd3:  w = wb(WD_ADC1, 2'd0, 1'b1);
      PC_DATA + 6'd4:  w = wb(WD_ADC1, 2'd1, 1'b1);
      PC_DATA + 6'd5:  w = wb(WD_ADC2, 2'd0, 1'b1);
      PC_DATA + 6'd6:  w = wb(WD_ADC2, 2'd1, 1'b1);
      PC_DATA + 6'd7:  w = wb(WD_ADC3, 2'd0, 1'b1);
      PC_DATA + 6'd8:  w = wb(WD_ADC3, 2'd1, 1'b1);
      PC_DATA + 6'd9:  w = cb(DATA_MARK, 1'b1);
      PC_DATA + 6'd10: w = go_trailer(wb(WD_PINS, 2'd0, 1'b1));
      // Status record.
      PC_STATUS:         w = wb(WD_NODE, 2'd0, 1'b1);
      PC_STATUS + 6'd1:  w = wb(WD_MODE, 2'd0, 1'b1);
      PC_STATUS + 6'd2:  w = wb(WD_RUN, 2'd0, 1'b1);
      PC_STATUS + 6'd3:  w = cb(PAD_BYTE, 1'b1);
      PC_STATUS + 6'd4:  w = wb(WD_ARATE, 2'd0, 1'b1);
      PC_STATUS + 6'd5:  w = wb(WD_ARATE, 2'd1, 1'b1);
      PC_STATUS + 6'd6:  w = wb(WD_ARATE, 2'd2, 1'b1);
      PC_STATUS + 6'd7:  w = wb(WD_ARATE, 2'd3, 1'b1);
      PC_STATUS + 6'd8:  w = wb(WD_DRATE, 2'd0, 1'b1);
      PC_STATUS + 6'd9:  w = wb(WD_DRATE, 2'd1, 1'b1);
      PC_STATUS + 6'd10: w = wb(WD_DRATE, 2'd2, 1'b1);
      PC_STATUS + 6'd11: w = wb(WD_DRATE, 2'd3, 1'b1);
      PC_STATUS + 6'd12: w = wb(WD_SAMPLES, 2'd0, 1'b1);
      PC_STATUS + 6'd13: w = wb(WD_SAMPLES, 2'd1, 1'b1);
      PC_STATUS + 6'd14: w = wb(WD_SAMPLES, 2'd2, 1'b1);
      PC_STATUS + 6'd15: w = wb(WD_SAMPLES, 2'd3, 1'b1);
      PC_STATUS + 6'd16: w = wb(WD_CLOCK, 2'd0, 1'b1);
      PC_STATUS + 6'd17: w = wb(WD_CLOCK, 2'd1, 1'b1);
      PC_STATUS + 6'd18: w = wb(WD_CLOCK, 2'd2, 1'b1);
      PC_STATUS + 6'd19: w = wb(WD_CLOCK, 2'd3, 1'b1);
      PC_STATUS + 6'd20: w = wb(WD_FAULT, 2'd0, 1'b1);
      PC_STATUS + 6'd21: w = cb(PAD_BYTE, 1'b1);
      PC_STATUS + 6'd22: w = cb(PAD_BYTE, 1'b1);
      PC_STATUS + 6'd23: w = cb(PAD_BYTE, 1'b1);
      PC_STATUS + 6'd24: w = wb(WD_TEMP, 2'd0, 1'b1);
      PC_STATUS + 6'd25: w = wb(WD_TEMP, 2'd1, 1'b1);
      PC_STATUS + 6'd26: w = wb(WD_TEMP, 2'd2, 1'b1);
      PC_STATUS + 6'd27: w = go_trailer(wb(WD_TEMP, 2'd3, 1'b1));
      // Unused addresses close the frame.
      default: begin
        w = cb(EOF_BYTE, 1'b0);
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // CRC-16/XMODEM update by one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cfru_if.sv]
// Request and response channel interfaces of the command frame responder.
// Standalone; carries valid, ready and the payload fields of each channel.
`default_nettype none

// Decoded command frame with current sensor values.
interface cfru_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_start;
  logic [7:0]  command;
  logic [31:0] argument;
  logic [11:0] adc_sample_0;
  logic [11:0] adc_sample_1;
  logic [11:0] adc_sample_2;
  logic [11:0] adc_sample_3;
  logic [7:0]  pin_levels;
  logic [31:0] temperature_bits;
  logic [31:0] core_voltage_bits;
  logic [31:0] clock_frequency;

  modport source (
    output valid, frame_start, command, argument, adc_sample_0, adc_sample_1,
           adc_sample_2, adc_sample_3, pin_levels, temperature_bits,
           core_voltage_bits, clock_frequency,
    input  ready
  );

  modport sink (
    input  valid, frame_start, command, argument, adc_sample_0, adc_sample_1,
           adc_sample_2, adc_sample_3, pin_levels, temperature_bits,
           core_voltage_bits, clock_frequency,
    output ready
  );
endinterface

// One response frame byte per request.
interface cfru_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] response_byte;
  logic       frame_end;

  modport source (
    output valid, response_byte, frame_end,
    input  ready
  );

  modport sink (
    input  valid, response_byte, frame_end,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/command_frame_responder_unit.sv]
// Command frame responder: a microcoded sequencer emits one response byte per step.
// The first byte (0xAA) is presented once the request is registered and the first step has run.
// A frame of payload length L is L+6 bytes (7 to 34); the next request is taken only after
// the closing byte is issued. A frame with a bad start byte is taken and produces no bytes.
// Bytes leave the single output byte register, one per microcode step; steps wait on back-pressure.
// Reset (synchronous) clears the sequencer and output valid and restores the configuration and status registers.
`default_nettype none

module command_frame_responder_unit
  import cfru_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  cfru_cmd_if.sink      cmd,
  cfru_rsp_if.source    resp,
  input  logic          wr_en,
  input  logic [1:0]    wr_index,
  input  logic [31:0]   wr_data
);

  // Control state.
  logic        busy;
  pc_t         pc;
  logic        out_valid;

  // Configuration and status registers.
  logic [7:0]  node_number;
  logic [31:0] digital_capture_rate;
  logic [7:0]  fault_code;
  logic        running;
  logic [7:0]  op_mode;
  logic [31:0] analog_rate;
  logic [31:0] samples_taken;
  logic [31:0] clock_setting_khz;

  // Request snapshot and output payload.
  pc_t         entry;
  len_t        len;
  logic [11:0] adc0, adc1, adc2, adc3;
  logic [7:0]  pins;
  logic [31:0] temp;
  logic [31:0] test_value;
  logic [7:0]  out_byte;
  logic        out_end;

  // Decode results.
  logic        accept;
  logic        good;
  pc_t         entry_next;
  len_t        len_next;
  logic [31:0] test_value_next;
  logic        running_next;
  logic [7:0]  op_mode_next;
  logic [31:0] analog_rate_next;
  logic [31:0] samples_taken_next;
  logic [31:0] clock_setting_khz_next;

  // Sequencer signals.
  ucw_t        uc;
  logic        fire;
  pc_t         pc_next;
  logic [31:0] word_val;
  logic [7:0]  word_byte;
  logic [7:0]  step_byte;
  logic [15:0] crc;
  crc_ctl_t    crc_ctl;

  assign accept = cmd.valid && cmd.ready;
  assign good   = (cmd.frame_start == SOF_BYTE);
  assign cmd.ready = !busy;

  assign resp.valid         = out_valid;
  assign resp.response_byte = out_byte;
  assign resp.frame_end     = out_end;

  // Command decode: routine entry, payload length and register updates.
  always_comb begin
    entry_next             = PC_ACK;
    len_next               = LEN_SHORT;
    test_value_next        = cmd.core_voltage_bits;
    running_next           = running;
    op_mode_next           = op_mode;
    analog_rate_next       = analog_rate;
    samples_taken_next     = samples_taken;
    clock_setting_khz_next = clock_setting_khz;
    unique case (cmd.command)
      CMD_NOP:       entry_next = PC_NOP;
      CMD_STATUS: begin
        entry_next = PC_STATUS;
        len_next   = LEN_STATUS;
      end
      CMD_START:     running_next = 1'b1;
      CMD_STOP:      running_next = 1'b0;
      CMD_RATE_WR:   analog_rate_next = cmd.argument;
      CMD_SAMPLE_RD: begin
        entry_next         = PC_DATA;
        len_next           = LEN_DATA;
        samples_taken_next = samples_taken + 32'd1;
      end
      CMD_MODE_WR:   op_mode_next = cmd.argument[7:0];
      CMD_CLK_BOOST: begin
        clock_setting_khz_next = (cmd.argument[7:0] == OC_FAST_SEL) ? KHZ_FAST : KHZ_BASE;
      end
      CMD_SELF_TEST: begin
        unique case (cmd.argument[7:0])
          TEST_VOLT: begin
            entry_next      = PC_TEST;
            len_next        = LEN_TEST;
            test_value_next = cmd.core_voltage_bits;
          end
          TEST_TEMP: begin
            entry_next      = PC_TEST;
            len_next        = LEN_TEST;
            test_value_next = cmd.temperature_bits;
          end
          TEST_CLOCK: begin
            entry_next      = PC_TEST;
            len_next        = LEN_TEST;
            test_value_next = cmd.clock_frequency;
          end
          default: entry_next = PC_ACK;
        endcase
      end
      CMD_FAULT_INJ: entry_next = PC_ACK;
      default:       entry_next = PC_NAK;
    endcase
  end

  // Microcode fetch and step enable: a step runs when the output slot is free.
  assign uc   = ucode(pc);
  assign fire = busy && (!out_valid || resp.ready);

  // Next step address.
  always_comb begin
    unique case (uc.jump)
      JMP_SEQ:      pc_next = pc + 6'd1;
      JMP_GOTO:     pc_next = uc.target;
      JMP_DISPATCH: pc_next = entry;
      default:      pc_next = pc + 6'd1;
    endcase
  end

  // Datapath word select.
  always_comb begin
    unique case (uc.word)
      WD_LEN:     word_val = {27'd0, len};
      WD_NODE:    word_val = {24'd0, node_number};
      WD_MODE:    word_val = {24'd0, op_mode};
      WD_RUN:     word_val = {31'd0, running};
      WD_ARATE:   word_val = analog_rate;
      WD_DRATE:   word_val = digital_capture_rate;
      WD_SAMPLES: word_val = samples_taken;
      WD_CLOCK:   word_val = clock_setting_khz;
      WD_FAULT:   word_val = {24'd0, fault_code};
      WD_TEMP:    word_val = temp;
      WD_ADC0:    word_val = {20'd0, adc0};
      WD_ADC1:    word_val = {20'd0, adc1};
      WD_ADC2:    word_val = {20'd0, adc2};
      WD_ADC3:    word_val = {20'd0, adc3};
      WD_PINS:    word_val = {24'd0, pins};
      WD_TEST:    word_val = test_value;
      default:    word_val = '0;
    endcase
  end

  assign word_byte = word_val[{uc.idx, 3'b000} +: 8];

  // Byte source select.
  always_comb begin
    unique case (uc.kind)
      SRC_CONST:  step_byte = uc.value;
      SRC_WORD:   step_byte = word_byte;
      SRC_CRC_LO: step_byte = crc[7:0];
      SRC_CRC_HI: step_byte = crc[15:8];
      default:    step_byte = uc.value;
    endcase
  end

  // Payload CRC.
  assign crc_ctl.clear  = accept;
  assign crc_ctl.update = fire && uc.crc;

  cfru_crc u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (step_byte),
    .crc  (crc)
  );

  // Sequencer, output handshake and register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy                 <= 1'b0;
      pc                   <= PC_SOF;
      out_valid            <= 1'b0;
      node_number          <= '0;
      digital_capture_rate <= DIGITAL_RATE_RST;
      fault_code           <= '0;
      running              <= 1'b0;
      op_mode              <= '0;
      analog_rate          <= ANALOG_RATE_RST;
      samples_taken        <= '0;
      clock_setting_khz    <= KHZ_BASE;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_NODE:  node_number <= wr_data[7:0];
          REG_DRATE: digital_capture_rate <= wr_data;
          REG_FAULT: fault_code <= wr_data[7:0];
          default: ;
        endcase
      end
      if (accept && good) begin
        busy              <= 1'b1;
        pc                <= PC_SOF;
        running           <= running_next;
        op_mode           <= op_mode_next;
        analog_rate       <= analog_rate_next;
        samples_taken     <= samples_taken_next;
        clock_setting_khz <= clock_setting_khz_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
        pc        <= pc_next;
        if (uc.last) begin
          busy <= 1'b0;
        end
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request snapshot and output byte register.
  always_ff @(posedge clk) begin
    if (accept) begin
      entry      <= entry_next;
      len        <= len_next;
      adc0       <= cmd.adc_sample_0;
      adc1       <= cmd.adc_sample_1;
      adc2       <= cmd.adc_sample_2;
      adc3       <= cmd.adc_sample_3;
      pins       <= cmd.pin_levels;
      temp       <= cmd.temperature_bits;
      test_value <= test_value_next;
    end
    if (fire) begin
      out_byte <= step_byte;
      out_end  <= uc.last;
    end
  end

`ifndef SYNTHESIS
  // The end-of-frame flag only ever marks the closing byte.
  a_eof_byte: assert property (@(posedge clk) disable iff (rst)
    resp.valid && resp.frame_end |-> resp.response_byte == EOF_BYTE)
    else $error("frame_end set on a byte other than the closing byte");

  // The step counter stays inside the microprogram while a frame runs.
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= PC_LAST)
    else $error("sequencer left the microprogram");

  // A well-formed request starts the program at the header.
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && cmd.frame_start == SOF_BYTE |=> busy && pc == PC_SOF)
    else $error("accepted frame did not start the sequencer");

  // Issuing the closing byte releases the sequencer.
  a_frame_done: assert property (@(posedge clk) disable iff (rst)
    fire && uc.last |=> !busy && resp.valid && resp.frame_end)
    else $error("sequencer still busy after the closing byte");
`endif

endmodule

`default_nettype wire

[hw/rtl/cfru_crc.sv]
// CRC-16/XMODEM accumulator over the response payload bytes.
// Depends on cfru_pkg for the control struct and the byte update function.
`default_nettype none

module cfru_crc
  import cfru_pkg::*;
(
  input  logic        clk,
  input  crc_ctl_t    ctl,
  input  logic [7:0]  data,
  output logic [15:0] crc
);

  // Cleared when a frame starts, folded in one byte per payload step.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      crc <= '0;
    end else if (ctl.update) begin
      crc <= crc_byte(crc, data);
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for command_frame_responder_unit: drives decoded command
// frames, predicts every response byte and compares it as it leaves the block.
// Depends on cfru_pkg (codes and constants) and on the cfru_cmd_if and cfru_rsp_if interfaces.

module testbench
  import cfru_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code outside the decoded set, used to hit the unknown-command path.
  localparam logic [7:0] CMD_RESERVED = 8'd7;

  typedef struct {
    logic [7:0]  frame_start;
    logic [7:0]  command;
    logic [31:0] argument;
    logic [11:0] adc_sample_0;
    logic [11:0] adc_sample_1;
    logic [11:0] adc_sample_2;
    logic [11:0] adc_sample_3;
    logic [7:0]  pin_levels;
    logic [31:0] temperature_bits;
    logic [31:0] core_voltage_bits;
    logic [31:0] clock_frequency;
  } request_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  typedef logic [7:0] octet_q_t[$];

  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;

  cfru_cmd_if cmd_ch ();
  cfru_rsp_if resp_ch ();

  command_frame_responder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .resp     (resp_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Shadow copies of the configuration and of the status registers.
  logic [7:0]  cfg_node  = 8'h00;
  logic [31:0] cfg_drate = DIGITAL_RATE_RST;
  logic [7:0]  cfg_fault = 8'h00;
  logic        st_running = 1'b0;
  logic [7:0]  st_mode    = 8'h00;
  logic [31:0] st_arate   = ANALOG_RATE_RST;
  logic [31:0] st_samples = 32'd0;
  logic [31:0] st_khz     = KHZ_BASE;

  frame_byte_t pending_bytes[$];
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int          mismatches = 0;

  logic [7:0] command_set [11] = '{CMD_NOP, CMD_STATUS, CMD_START, CMD_STOP, CMD_RATE_WR,
                                   CMD_SAMPLE_RD, CMD_MODE_WR, CMD_CLK_BOOST, CMD_SELF_TEST,
                                   CMD_FAULT_INJ, CMD_RESERVED};

  always #5 clk = ~clk;

  // Append a 32-bit word in little-endian order.
  function automatic void add_word(ref octet_q_t q, input logic [31:0] w);
    for (int k = 0; k < 4; k++) begin
      q.push_back(w[8*k +: 8]);
    end
  endfunction

  // Work out the response frame of one accepted request and update the shadow state.
  function automatic void predict_response(input request_t r);
    octet_q_t    payload;
    logic [15:0] crc;
    logic [7:0]  sel;
    frame_byte_t fb;
    sel = r.argument[7:0];
    if (r.frame_start != SOF_BYTE) return;
    case (r.command)
      CMD_NOP: payload.push_back(NOP_BYTE);
      CMD_STATUS: begin
        payload.push_back(cfg_node);
        payload.push_back(st_mode);
        payload.push_back({7'd0, st_running});
        payload.push_back(PAD_BYTE);
        add_word(payload, st_arate);
        add_word(payload, cfg_drate);
        add_word(payload, st_samples);
        add_word(payload, st_khz);
        payload.push_back(cfg_fault);
        repeat (3) payload.push_back(PAD_BYTE);
        add_word(payload, r.temperature_bits);
      end
      CMD_START: begin
        st_running = 1'b1;
        payload.push_back(ACK_BYTE);
      end
      CMD_STOP: begin
        st_running = 1'b0;
        payload.push_back(ACK_BYTE);
      end
      CMD_RATE_WR: begin
        st_arate = r.argument;
        payload.push_back(ACK_BYTE);
      end
      CMD_SAMPLE_RD: begin
        payload.push_back(ACK_BYTE);
        payload.push_back(r.adc_sample_0[7:0]);
        payload.push_back({4'd0, r.adc_sample_0[11:8]});
        payload.push_back(r.adc_sample_1[7:0]);
        payload.push_back({4'd0, r.adc_sample_1[11:8]});
        payload.push_back(r.adc_sample_2[7:0]);
        payload.push_back({4'd0, r.adc_sample_2[11:8]});
        payload.push_back(r.adc_sample_3[7:0]);
        payload.push_back({4'd0, r.adc_sample_3[11:8]});
        payload.push_back(DATA_MARK);
        payload.push_back(r.pin_levels);
        st_samples = st_samples + 32'd1;
      end
      CMD_MODE_WR: begin
        st_mode = sel;
        payload.push_back(ACK_BYTE);
      end
      CMD_CLK_BOOST: begin
        st_khz = (sel == OC_FAST_SEL) ? KHZ_FAST : KHZ_BASE;
        payload.push_back(ACK_BYTE);
      end
      CMD_SELF_TEST: begin
        payload.push_back(ACK_BYTE);
        if (sel == TEST_VOLT) add_word(payload, r.core_voltage_bits);
        else if (sel == TEST_TEMP) add_word(payload, r.temperature_bits);
        else if (sel == TEST_CLOCK) add_word(payload, r.clock_frequency);
      end
      CMD_FAULT_INJ: payload.push_back(ACK_BYTE);
      default: payload.push_back(NAK_BYTE);
    endcase

    // CRC-16/XMODEM over the payload, MSB first.
    crc = 16'h0000;
    foreach (payload[i]) begin
      crc = crc ^ {payload[i], 8'h00};
      repeat (8) crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
    end

    // Header, payload and trailer in transmit order.
    fb.last = 1'b0;
    fb.value = SOF_BYTE;
    pending_bytes.push_back(fb);
    fb.value = 8'(payload.size());
    pending_bytes.push_back(fb);
    fb.value = 8'h00;
    pending_bytes.push_back(fb);
    foreach (payload[i]) begin
      fb.value = payload[i];
      pending_bytes.push_back(fb);
    end
    fb.value = crc[7:0];
    pending_bytes.push_back(fb);
    fb.value = crc[15:8];
    pending_bytes.push_back(fb);
    fb.value = EOF_BYTE;
    fb.last = 1'b1;
    pending_bytes.push_back(fb);
  endfunction

  // A request with the given header and random sensor readings.
  function automatic request_t make_request(input logic [7:0] start, input logic [7:0] code,
                                            input logic [31:0] arg);
    request_t r;
    r.frame_start       = start;
    r.command           = code;
    r.argument          = arg;
    r.adc_sample_0      = 12'($urandom_range(4095));
    r.adc_sample_1      = 12'($urandom_range(4095));
    r.adc_sample_2      = 12'($urandom_range(4095));
    r.adc_sample_3      = 12'($urandom_range(4095));
    r.pin_levels        = 8'($urandom_range(255));
    r.temperature_bits  = $urandom;
    r.core_voltage_bits = $urandom;
    r.clock_frequency   = $urandom;
    return r;
  endfunction

  // Mostly well-formed frames; some unknown commands and some bad start bytes.
  function automatic request_t random_request();
    logic [7:0]  code;
    logic [7:0]  start;
    logic [31:0] arg;
    code = command_set[$urandom_range(10)];
    if ($urandom_range(7) == 0) code = 8'($urandom_range(255, CMD_FAULT_INJ + 1));
    arg = $urandom;
    if ($urandom_range(1) == 1) arg[7:0] = 8'($urandom_range(3));
    start = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : SOF_BYTE;
    return make_request(start, code, arg);
  endfunction

  // Offer one request, with random gaps before it, and predict it once taken.
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid             <= 1'b1;
    cmd_ch.frame_start       <= r.frame_start;
    cmd_ch.command           <= r.command;
    cmd_ch.argument          <= r.argument;
    cmd_ch.adc_sample_0      <= r.adc_sample_0;
    cmd_ch.adc_sample_1      <= r.adc_sample_1;
    cmd_ch.adc_sample_2      <= r.adc_sample_2;
    cmd_ch.adc_sample_3      <= r.adc_sample_3;
    cmd_ch.pin_levels        <= r.pin_levels;
    cmd_ch.temperature_bits  <= r.temperature_bits;
    cmd_ch.core_voltage_bits <= r.core_voltage_bits;
    cmd_ch.clock_frequency   <= r.clock_frequency;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_response(r);
  endtask

  // Stop offering requests and let every predicted byte drain out of the block.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all three configuration registers back to back; the block must be idle.
  task automatic program_regs(input logic [7:0] node, input logic [31:0] drate,
                              input logic [7:0] fault);
    wr_en    <= 1'b1;
    wr_index <= REG_NODE;
    wr_data  <= {24'd0, node};
    @(posedge clk);
    wr_index <= REG_DRATE;
    wr_data  <= drate;
    @(posedge clk);
    wr_index <= REG_FAULT;
    wr_data  <= {24'd0, fault};
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_node  = node;
    cfg_drate = drate;
    cfg_fault = fault;
  endtask

  // Response side: random back-pressure on the byte stream, held off during reset.
  always @(posedge clk) begin
    resp_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Compare each byte that leaves the block with the oldest prediction.
  always @(posedge clk) begin : check_bytes
    frame_byte_t want;
    if (!rst && resp_ch.valid && resp_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected response byte %h (frame_end %b)", $time,
                 resp_ch.response_byte, resp_ch.frame_end);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (resp_ch.response_byte !== want.value) begin
          $display("%0t: response_byte expected %h, actual %h", $time, want.value,
                   resp_ch.response_byte);
          mismatches++;
        end
        if (resp_ch.frame_end !== want.last) begin
          $display("%0t: frame_end expected %b, actual %b", $time, want.last,
                   resp_ch.frame_end);
          mismatches++;
        end
      end
    end
  end

  // Status record right after reset shows the reset values; get data bumps the count.
  task automatic test_reset_state();
    send_request(make_request(SOF_BYTE, CMD_STATUS, 32'd0));
    send_request(make_request(SOF_BYTE, CMD_SAMPLE_RD, 32'd0));
    send_request(make_request(SOF_BYTE, CMD_STATUS, 32'd0));
  endtask

  // Every command, the argument extremes and the special cases.
  task automatic test_command_set();
    request_t r;
    send_request(make_request(SOF_BYTE, CMD_NOP, 32'd0));
    send_request(make_request(SOF_BYTE, CMD_START, 32'hFFFF_FFFF));
    send_request(make_request(SOF_BYTE, CMD_STATUS, 32'd0));
    send_request(make_request(SOF_BYTE, CMD_STOP, 32'd0));
    send_request(make_request(SOF_BYTE, CMD_RATE_WR, 32'hFFFF_FFFF));
    send_request(make_request(SOF_BYTE, CMD_MODE_WR, 32'h1234_56FF));
    // Only the low argument byte selects the fast clock.
    send_request(make_request(SOF_BYTE, CMD_CLK_BOOST, {24'h000001, OC_FAST_SEL}));
    send_request(make_request(SOF_BYTE, CMD_STATUS, 32'd0));
    send_request(make_request(SOF_BYTE, CMD_CLK_BOOST, 32'h0000_0100));
    // Sample and pin extremes.
    r = make_request(SOF_BYTE, CMD_SAMPLE_RD, 32'd0);
    r.adc_sample_0 = 12'hFFF;
    r.adc_sample_1 = 12'hFFF;
    r.adc_sample_2 = 12'hFFF;
    r.adc_sample_3 = 12'hFFF;
    r.pin_levels   = 8'hFF;
    send_request(r);
    r.adc_sample_0 = 12'h000;
    r.adc_sample_1 = 12'h000;
    r.adc_sample_2 = 12'h000;
    r.adc_sample_3 = 12'h000;
    r.pin_levels   = 8'h00;
    send_request(r);
    // Hardware test on each source, then unknown test types.
    r = make_request(SOF_BYTE, CMD_SELF_TEST, {24'd0, TEST_VOLT});
    r.core_voltage_bits = 32'hFFFF_FFFF;
    send_request(r);
    send_request(make_request(SOF_BYTE, CMD_SELF_TEST, {24'hFFFFFF, TEST_TEMP}));
    send_request(make_request(SOF_BYTE, CMD_SELF_TEST, {24'hFFFFFF, TEST_CLOCK}));
    send_request(make_request(SOF_BYTE, CMD_SELF_TEST, 32'd3));
    send_request(make_request(SOF_BYTE, CMD_SELF_TEST, 32'h0000_00FF));
    send_request(make_request(SOF_BYTE, CMD_FAULT_INJ, 32'd0));
    // Unknown commands answer with a negative acknowledge.
    send_request(make_request(SOF_BYTE, CMD_RESERVED, 32'd0));
    send_request(make_request(SOF_BYTE, CMD_FAULT_INJ + 8'd1, 32'd0));
    send_request(make_request(SOF_BYTE, 8'hFF, 32'd0));
    // Bad start bytes produce nothing and change nothing.
    send_request(make_request(8'h00, CMD_STATUS, 32'd0));
    send_request(make_request(8'hAB, CMD_START, 32'd0));
    send_request(make_request(8'h2A, CMD_RATE_WR, 32'd0));
    send_request(make_request(SOF_BYTE, CMD_RATE_WR, 32'd0));
    send_request(make_request(SOF_BYTE, CMD_STATUS, 32'd0));
  endtask

  // Configuration at both extremes, each read back through a status record.
  task automatic test_register_extremes();
    request_t r;
    wait_drained();
    program_regs(8'hFF, 32'hFFFF_FFFF, 8'hFF);
    r = make_request(SOF_BYTE, CMD_STATUS, 32'd0);
    r.temperature_bits = 32'hFFFF_FFFF;
    send_request(r);
    wait_drained();
    program_regs(8'h00, 32'd0, 8'h00);
    r.temperature_bits = 32'd0;
    send_request(r);
  endtask

  // Random requests under one idling pattern, with a fresh random configuration.
  task automatic test_random_traffic(input int count, input int unsigned gap_pct,
                                     input int unsigned stall);
    wait_drained();
    program_regs(8'($urandom_range(255)), $urandom, 8'($urandom_range(255)));
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    for (int i = 0; i < count; i++) begin
      // Now and then hold off until the block has emptied.
      if (i == count / 2 || $urandom_range(19) == 0) wait_drained();
      send_request(random_request());
    end
  endtask

  // Test sequence.
  initial begin
    rst                      <= 1'b1;
    wr_en                    <= 1'b0;
    wr_index                 <= REG_NODE;
    wr_data                  <= 32'd0;
    cmd_ch.valid             <= 1'b0;
    cmd_ch.frame_start       <= 8'd0;
    cmd_ch.command           <= 8'd0;
    cmd_ch.argument          <= 32'd0;
    cmd_ch.adc_sample_0      <= 12'd0;
    cmd_ch.adc_sample_1      <= 12'd0;
    cmd_ch.adc_sample_2      <= 12'd0;
    cmd_ch.adc_sample_3      <= 12'd0;
    cmd_ch.pin_levels        <= 8'd0;
    cmd_ch.temperature_bits  <= 32'd0;
    cmd_ch.core_voltage_bits <= 32'd0;
    cmd_ch.clock_frequency   <= 32'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct = 22;
    stall_pct    = 45;
    test_reset_state();
    test_command_set();
    test_register_extremes();
    test_random_traffic(25, 22, 45);
    test_random_traffic(25, 45, 22);
    test_random_traffic(20, 0, 0);
    wait_drained();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/cfru_pkg.sv
hw/rtl/cfru_if.sv
hw/rtl/cfru_crc.sv
hw/rtl/command_frame_responder_unit.sv
bench/testbench.sv
